/* sv/arxks_pkg.sv */
// Shared constants, types and helper functions for the ARX keystream block.
`timescale 1ns / 1ps

package arxks_pkg;

   // Word and register geometry
   localparam int WORD_W    = 32;
   localparam int CFG_W     = 64;
   localparam int NUM_WORDS = 8;
   localparam int STEP_W    = $clog2(NUM_WORDS);
   localparam int CSR_IDX_W = 3;
   localparam int COUNT_W   = 3;
   localparam int ROT_AMT   = 2;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_0_7    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_8_15   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_16_23  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_24_31  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_NONCE_0_7  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_NONCE_8_15 = 3'd5;
   localparam int                   NUM_CSR        = 6;

   // Request action codes
   localparam logic ACTION_INIT = 1'b0;
   localparam logic ACTION_DATA = 1'b1;

   // Byte lane masks
   localparam logic [WORD_W-1:0] WORD_MASK  = 32'hFFFF_FFFF;
   localparam logic [WORD_W-1:0] BYTE0_MASK = 32'h0000_00FF;
   localparam logic [WORD_W-1:0] BYTE1_MASK = 32'h0000_FF00;
   localparam logic [WORD_W-1:0] BYTE2_MASK = 32'h00FF_0000;
   localparam logic [WORD_W-1:0] BYTE3_MASK = 32'hFF00_0000;

   localparam logic [COUNT_W-1:0] COUNT_FULL = 3'd4;

   // Keystream fold steps, one per cycle
   typedef enum logic [1:0] {
      FOLD_FIRST  = 2'd0,   // w0 + w6
      FOLD_SECOND = 2'd1,   // (v ^ w1) + w5
      FOLD_THIRD  = 2'd2,   // (v ^ w2) + w4
      FOLD_LAST   = 2'd3    // (v ^ w3) + w7
   } fold_sel_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic         load_init;     // load key and nonce, clear acc and counter
      logic         capture_data;  // hold the data word and byte count
      logic         sum_step;      // add word 0 into acc, rotate words
      logic         round_step;    // one ARX update, rotate words
      logic         fold_step;     // one keystream fold step
      fold_sel_type fold_sel;
      logic         emit;          // load the result register
   } arxks_cmd_type;

   // Clamp a byte count to four
   function automatic logic [COUNT_W-1:0] sat_count(input logic [COUNT_W-1:0] cnt);
      sat_count = (cnt > COUNT_FULL) ? COUNT_FULL : cnt;
   endfunction

   // Mask of the valid low bytes for a clamped count
   function automatic logic [WORD_W-1:0] byte_mask(input logic [COUNT_W-1:0] cnt);
      logic [WORD_W-1:0] m;
      m = '0;
      if (cnt >= 3'd1) m = m | BYTE0_MASK;
      if (cnt >= 3'd2) m = m | BYTE1_MASK;
      if (cnt >= 3'd3) m = m | BYTE2_MASK;
      if (cnt >= 3'd4) m = m | BYTE3_MASK;
      byte_mask = m;
   endfunction

   // Rotate a word left by two
   function automatic logic [WORD_W-1:0] rotl2(input logic [WORD_W-1:0] v);
      rotl2 = (v << ROT_AMT) | (v >> (WORD_W - ROT_AMT));
   endfunction

endpackage

/* sv/arxks_ctrl.sv */
// Controller state machine sequencing init, round, fold and result transfer.
`timescale 1ns / 1ps

module arxks_ctrl
   import arxks_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_action,
   output logic          req_stall,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output arxks_cmd_type cmd
);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_SUM   = 5'b00010,
      ST_ROUND = 5'b00100,
      ST_FOLD  = 5'b01000,
      ST_EMIT  = 5'b10000
   } state_type;

   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_WORDS - 1);
   localparam logic [STEP_W-1:0] LAST_FOLD = STEP_W'(FOLD_LAST);

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              init_ff, init_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              req_xfer;
   logic              out_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;

   // Next state and datapath commands
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      init_in      = init_ff;
      cmd          = '0;
      cmd.fold_sel = fold_sel_type'(step_ff[1:0]);
      case (state_ff)
         ST_IDLE: begin
            step_in = '0;
            if (req_xfer) begin
               if (req_action == ACTION_INIT) begin
                  cmd.load_init = 1'b1;
                  init_in       = 1'b1;
                  state_in      = ST_SUM;
               end else begin
                  cmd.capture_data = 1'b1;
                  init_in          = 1'b0;
                  state_in         = ST_ROUND;
               end
            end
         end
         ST_SUM: begin
            cmd.sum_step = 1'b1;
            step_in      = step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            cmd.round_step = 1'b1;
            step_in        = step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               state_in = init_ff ? ST_IDLE : ST_FOLD;
            end
         end
         ST_FOLD: begin
            cmd.fold_step = 1'b1;
            step_in       = step_ff + 1'b1;
            if (step_ff == LAST_FOLD) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // Wait until the result register is free
            if (out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold a result until its transfer completes
   assign rsp_valid_in = cmd.emit || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         init_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         init_ff      <= init_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> !(rsp_valid_ff && rsp_stall))
      else $error("result register overwritten before transfer");

   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EMIT))
      else $error("result raised outside emit state");

   a_init_to_sum: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && req_action == ACTION_INIT) |=> (state_ff == ST_SUM))
      else $error("init transfer did not start the sum pass");

   a_round_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND && step_ff != LAST_STEP) |=> (state_ff == ST_ROUND))
      else $error("round left before eight updates");

endmodule

/* sv/arxks_dp.sv */
// Datapath: config registers, rotating round words, accumulator, fold and result.
`timescale 1ns / 1ps

module arxks_dp
   import arxks_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata,
   input  logic [WORD_W-1:0]    req_data_in,
   input  logic [COUNT_W-1:0]   req_byte_count,
   input  arxks_cmd_type        cmd,
   output logic [WORD_W-1:0]    rsp_data_out,
   output logic [COUNT_W-1:0]   rsp_valid_bytes
);

   localparam int HALF = CFG_W / 2;

   logic [CFG_W-1:0]  cfg_ff [NUM_CSR];
   logic [WORD_W-1:0] words_ff [NUM_WORDS];
   logic [WORD_W-1:0] words_in [NUM_WORDS];
   logic [WORD_W-1:0] key_words [NUM_WORDS];
   logic [WORD_W-1:0] acc_ff, acc_in;
   logic [WORD_W-1:0] ctr_ff, ctr_in;
   logic [WORD_W-1:0] ks_ff, ks_in;
   logic [WORD_W-1:0] data_ff;
   logic [COUNT_W-1:0] count_ff;
   logic [WORD_W-1:0] out_data_ff;
   logic [COUNT_W-1:0] out_count_ff;
   logic [WORD_W-1:0] upd_word;
   logic [WORD_W-1:0] fold_a, fold_b, fold_c;

   // Configuration writes; indexes past the last register are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < NUM_CSR; r++) begin
            cfg_ff[r] <= '0;
         end
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_KEY_0_7:    cfg_ff[0] <= csr_wdata;
            CSR_KEY_8_15:   cfg_ff[1] <= csr_wdata;
            CSR_KEY_16_23:  cfg_ff[2] <= csr_wdata;
            CSR_KEY_24_31:  cfg_ff[3] <= csr_wdata;
            CSR_NONCE_0_7:  cfg_ff[4] <= csr_wdata;
            CSR_NONCE_8_15: cfg_ff[5] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Big-endian key words with the nonce folded into the upper half
   always_comb begin
      for (int i = 0; i < NUM_WORDS / 2; i++) begin
         key_words[2*i]   = cfg_ff[i][CFG_W-1:HALF];
         key_words[2*i+1] = cfg_ff[i][HALF-1:0];
      end
      key_words[4] = key_words[4] ^ cfg_ff[4][CFG_W-1:HALF];
      key_words[5] = key_words[5] ^ cfg_ff[4][HALF-1:0];
      key_words[6] = key_words[6] ^ cfg_ff[5][CFG_W-1:HALF];
      key_words[7] = key_words[7] ^ cfg_ff[5][HALF-1:0];
   end

   // One ARX update on the word at the head of the ring
   assign upd_word = rotl2((words_ff[0] + words_ff[1] + acc_ff) ^ words_ff[0]);

   // Advance the word ring, accumulator and counter
   always_comb begin
      for (int i = 0; i < NUM_WORDS; i++) begin
         words_in[i] = words_ff[i];
      end
      acc_in = acc_ff;
      ctr_in = ctr_ff;
      if (cmd.load_init) begin
         for (int i = 0; i < NUM_WORDS; i++) begin
            words_in[i] = key_words[i];
         end
         acc_in = '0;
         ctr_in = '0;
      end else if (cmd.sum_step) begin
         for (int i = 0; i < NUM_WORDS - 1; i++) begin
            words_in[i] = words_ff[i+1];
         end
         words_in[NUM_WORDS-1] = words_ff[0];
         acc_in = acc_ff + words_ff[0];
      end else if (cmd.round_step) begin
         for (int i = 0; i < NUM_WORDS - 1; i++) begin
            words_in[i] = words_ff[i+1];
         end
         words_in[NUM_WORDS-1] = upd_word;
         acc_in = acc_ff + upd_word + ctr_ff;
         ctr_in = ctr_ff + 1'b1;
      end
   end

   // Keystream fold operands for the current step
   always_comb begin
      case (cmd.fold_sel)
         FOLD_FIRST: begin
            fold_a = words_ff[0];
            fold_b = '0;
            fold_c = words_ff[6];
         end
         FOLD_SECOND: begin
            fold_a = ks_ff;
            fold_b = words_ff[1];
            fold_c = words_ff[5];
         end
         FOLD_THIRD: begin
            fold_a = ks_ff;
            fold_b = words_ff[2];
            fold_c = words_ff[4];
         end
         FOLD_LAST: begin
            fold_a = ks_ff;
            fold_b = words_ff[3];
            fold_c = words_ff[7];
         end
         default: begin
            fold_a = ks_ff;
            fold_b = '0;
            fold_c = '0;
         end
      endcase
   end

   assign ks_in = cmd.fold_step ? ((fold_a ^ fold_b) + fold_c) : ks_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_WORDS; i++) begin
            words_ff[i] <= '0;
         end
         acc_ff <= '0;
         ctr_ff <= '0;
      end else begin
         for (int i = 0; i < NUM_WORDS; i++) begin
            words_ff[i] <= words_in[i];
         end
         acc_ff <= acc_in;
         ctr_ff <= ctr_in;
      end
   end

   // Payload registers: captured request, fold value and result
   always_ff @(posedge clock) begin
      ks_ff <= ks_in;
      if (cmd.capture_data) begin
         data_ff  <= req_data_in;
         count_ff <= sat_count(req_byte_count);
      end
      if (cmd.emit) begin
         out_data_ff  <= (data_ff ^ ks_ff) & byte_mask(count_ff) & WORD_MASK;
         out_count_ff <= count_ff;
      end
   end

   assign rsp_data_out    = out_data_ff;
   assign rsp_valid_bytes = out_count_ff;

endmodule

/* sv/arx_stream_cipher_keystream.sv */
// Top level of the ARX stream cipher keystream block.
// Data item: round updates (one word update per cycle through the
//   accumulator), then the fold steps and a result-load step that waits
//   while the result register is held; requests stall until it is idle again.
// Init item: an accumulator-sum pass, then a round pass, no result.
// Synchronous reset clears key, nonce, round words, accumulator and counter.
`timescale 1ns / 1ps

module arx_stream_cipher_keystream
   import arxks_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_action,
   input  logic [WORD_W-1:0]    req_data_in,
   input  logic [COUNT_W-1:0]   req_byte_count,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [WORD_W-1:0]    rsp_data_out,
   output logic [COUNT_W-1:0]   rsp_valid_bytes
);

   arxks_cmd_type cmd;

   arxks_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .req_stall  (req_stall),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .cmd        (cmd)
   );

   arxks_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_data_in     (req_data_in),
      .req_byte_count  (req_byte_count),
      .cmd             (cmd),
      .rsp_data_out    (rsp_data_out),
      .rsp_valid_bytes (rsp_valid_bytes)
   );

endmodule

/* tb/arx_stream_cipher_keystream_tb.sv */
// Self-checking testbench for the ARX stream cipher keystream block.
`timescale 1ns / 1ps

module arx_stream_cipher_keystream_tb;
   import arxks_pkg::*;

   localparam int  CYCLE_LIMIT  = 400000;
   localparam int  SETTLE_TICKS = 24;
   localparam int  PHASES       = 10;
   localparam int  PHASE_ITEMS  = 103;
   localparam logic [CFG_W-1:0] ALL_ONES = {CFG_W{1'b1}};

   typedef struct packed {
      logic [WORD_W-1:0]  data_out;
      logic [COUNT_W-1:0] valid_bytes;
   } cipher_result_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0]     csr_wdata = '0;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic                 req_action = ACTION_INIT;
   logic [WORD_W-1:0]    req_data_in = '0;
   logic [COUNT_W-1:0]   req_byte_count = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [WORD_W-1:0]    rsp_data_out;
   logic [COUNT_W-1:0]   rsp_valid_bytes;

   // Shadow of the cipher state and the key/nonce registers
   logic [WORD_W-1:0] cipher_words [NUM_WORDS];
   logic [WORD_W-1:0] mix_acc;
   logic [WORD_W-1:0] step_ctr;
   logic [CFG_W-1:0]  csr_shadow [NUM_CSR];

   cipher_result_type pending_results[$];
   int                failures    = 0;
   int                cycle_count = 0;
   int                idle_level  = 0;   // 0 none, 1 light, 2 heavy

   arx_stream_cipher_keystream u_top (
      .clock           (clock),
      .reset           (reset),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_data_in     (req_data_in),
      .req_byte_count  (req_byte_count),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_data_out    (rsp_data_out),
      .rsp_valid_bytes (rsp_valid_bytes)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Cipher predictor
   // ---------------------------------------------------------------------

   // Run eight dependent add-rotate-xor updates through the accumulator
   task automatic advance_round();
      logic [WORD_W-1:0] mixed;
      for (int i = 0; i < NUM_WORDS; i++) begin
         mixed = (cipher_words[i] + cipher_words[(i + 1) % NUM_WORDS] + mix_acc)
                 ^ cipher_words[i];
         cipher_words[i] = {mixed[WORD_W-3:0], mixed[WORD_W-1:WORD_W-2]};
         mix_acc  = mix_acc + cipher_words[i] + step_ctr;
         step_ctr = step_ctr + 1;
      end
   endtask

   // Fold the round words into one keystream word
   function automatic logic [WORD_W-1:0] fold_keystream();
      logic [WORD_W-1:0] v;
      v = cipher_words[0] + cipher_words[6];
      v = (v ^ cipher_words[1]) + cipher_words[5];
      v = (v ^ cipher_words[2]) + cipher_words[4];
      v = (v ^ cipher_words[3]) + cipher_words[7];
      return v;
   endfunction

   // Load key and nonce, seed the accumulator, then run the first round
   task automatic load_key_nonce();
      for (int i = 0; i < 4; i++) begin
         cipher_words[2*i]     = csr_shadow[i][CFG_W-1:WORD_W];
         cipher_words[2*i + 1] = csr_shadow[i][WORD_W-1:0];
      end
      cipher_words[4] ^= csr_shadow[CSR_NONCE_0_7][CFG_W-1:WORD_W];
      cipher_words[5] ^= csr_shadow[CSR_NONCE_0_7][WORD_W-1:0];
      cipher_words[6] ^= csr_shadow[CSR_NONCE_8_15][CFG_W-1:WORD_W];
      cipher_words[7] ^= csr_shadow[CSR_NONCE_8_15][WORD_W-1:0];
      step_ctr = '0;
      mix_acc  = '0;
      for (int i = 0; i < NUM_WORDS; i++)
         mix_acc = mix_acc + cipher_words[i];
      advance_round();
   endtask

   // Update the shadow state for one accepted request, queue its result
   task automatic predict_transfer(input logic action, input logic [WORD_W-1:0] data,
                                   input logic [COUNT_W-1:0] count);
      logic [COUNT_W-1:0] eff_count;
      logic [WORD_W-1:0]  lane_mask;
      cipher_result_type  res;
      if (action == ACTION_INIT) begin
         load_key_nonce();
      end else begin
         eff_count = (count > COUNT_FULL) ? COUNT_FULL : count;
         lane_mask = '0;
         for (int b = 0; b < eff_count; b++)
            lane_mask[8*b +: 8] = 8'hFF;
         advance_round();
         res.data_out    = (data ^ fold_keystream()) & lane_mask;
         res.valid_bytes = eff_count;
         pending_results.push_back(res);
      end
   endtask

   // ---------------------------------------------------------------------
   // Result side: stall bursts and checking
   // ---------------------------------------------------------------------

   // Stall the result channel in random bursts
   initial begin
      forever begin
         @(negedge clock);
         if (idle_level != 0 && $urandom_range(0, (idle_level == 2) ? 3 : 9) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 6)) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic note_failure(input string msg);
      if (failures < 10)
         $display("%s", msg);
      failures++;
   endtask

   // Compare each result transfer with the oldest prediction
   always @(posedge clock) begin : check_results
      cipher_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            note_failure($sformatf("unexpected result data_out=%h valid_bytes=%0d",
                                   rsp_data_out, rsp_valid_bytes));
         end else begin
            want = pending_results.pop_front();
            if (rsp_data_out !== want.data_out)
               note_failure($sformatf("data_out mismatch: expected %h, got %h",
                                      want.data_out, rsp_data_out));
            if (rsp_valid_bytes !== want.valid_bytes)
               note_failure($sformatf("valid_bytes mismatch: expected %0d, got %0d",
                                      want.valid_bytes, rsp_valid_bytes));
         end
      end
   end

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------

   // Offer one request, hold it until the transfer, then predict
   task automatic send_item(input logic action, input logic [WORD_W-1:0] data,
                            input logic [COUNT_W-1:0] count);
      int gap;
      gap = 0;
      if (idle_level != 0 && $urandom_range(0, (idle_level == 2) ? 2 : 7) == 0)
         gap = $urandom_range(1, 6);
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_action     <= action;
      req_data_in    <= data;
      req_byte_count <= count;
      do @(posedge clock); while (req_stall);
      predict_transfer(action, data, count);
   endtask

   // Drop the request and wait until every predicted result has arrived
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // Drain, then let an init still in flight finish before touching registers
   task automatic settle_block();
      drain_results();
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value;
      @(negedge clock);
      csr_write_en <= 1'b0;
      csr_shadow[idx] = value;
   endtask

   task automatic program_key_nonce(input logic [CFG_W-1:0] k0, input logic [CFG_W-1:0] k1,
                                    input logic [CFG_W-1:0] k2, input logic [CFG_W-1:0] k3,
                                    input logic [CFG_W-1:0] n0, input logic [CFG_W-1:0] n1);
      settle_block();
      write_csr(CSR_KEY_0_7,    k0);
      write_csr(CSR_KEY_8_15,   k1);
      write_csr(CSR_KEY_16_23,  k2);
      write_csr(CSR_KEY_24_31,  k3);
      write_csr(CSR_NONCE_0_7,  n0);
      write_csr(CSR_NONCE_8_15, n1);
   endtask

   function automatic logic [CFG_W-1:0] rand_reg();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return ALL_ONES;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Data with no init runs on the all-zero reset state
   task automatic test_data_before_init();
      send_item(ACTION_DATA, '0, COUNT_FULL);
      send_item(ACTION_DATA, WORD_MASK, COUNT_FULL);
      send_item(ACTION_DATA, 32'hA5C3_7E19, 3'd1);
   endtask

   // Every byte count: zero, short words, full and saturating values
   task automatic test_byte_counts();
      send_item(ACTION_INIT, '0, '0);
      for (int c = 0; c < 8; c++)
         send_item(ACTION_DATA, WORD_MASK, COUNT_W'(c));
   endtask

   // All-ones and mixed key/nonce, back-to-back inits with noise in the data fields
   task automatic test_key_extremes();
      program_key_nonce(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
      send_item(ACTION_INIT, WORD_MASK, 3'd7);
      send_item(ACTION_DATA, 32'h1234_5678, COUNT_FULL);
      send_item(ACTION_DATA, '0, 3'd2);
      program_key_nonce(64'h0001_0203_0405_0607, 64'h0809_0A0B_0C0D_0E0F,
                        64'h1011_1213_1415_1617, 64'h1819_1A1B_1C1D_1E1F,
                        '0, ALL_ONES);
      send_item(ACTION_INIT, 32'hDEAD_BEEF, 3'd0);
      send_item(ACTION_INIT, '0, COUNT_FULL);
      send_item(ACTION_DATA, 32'h8000_0001, 3'd3);
   endtask

   // Hold off requests until the result channel is empty, then resume
   task automatic test_drain_pause();
      for (int i = 0; i < 3; i++)
         send_item(ACTION_DATA, $urandom, COUNT_FULL);
      drain_results();
      for (int i = 0; i < 3; i++)
         send_item(ACTION_DATA, $urandom, COUNT_W'($urandom_range(1, 4)));
   endtask

   // Random phases: fresh key and nonce, init, then a mostly-data stream
   task automatic test_random_stream();
      logic [WORD_W-1:0]  data;
      logic [COUNT_W-1:0] count;
      for (int p = 0; p < PHASES; p++) begin
         idle_level = (p == PHASES - 1) ? 0 : (p % 3);
         case (p)
            0:       program_key_nonce('0, '0, '0, '0, ALL_ONES, ALL_ONES);
            1:       program_key_nonce(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, '0, '0);
            default: program_key_nonce(rand_reg(), rand_reg(), rand_reg(), rand_reg(),
                                       rand_reg(), rand_reg());
         endcase
         send_item(ACTION_INIT, $urandom, COUNT_W'($urandom));
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            case ($urandom_range(0, 9))
               0:       data = $urandom_range(0, 1) ? WORD_MASK : '0;
               default: data = $urandom;
            endcase
            count = ($urandom_range(0, 4) == 0) ? COUNT_W'($urandom)
                                                : COUNT_W'($urandom_range(1, 4));
            if ($urandom_range(0, 99) == 0)
               drain_results();
            if ($urandom_range(0, 24) == 0)
               send_item(ACTION_INIT, data, count);
            else
               send_item(ACTION_DATA, data, count);
         end
      end
   endtask

   initial begin
      for (int i = 0; i < NUM_WORDS; i++)
         cipher_words[i] = '0;
      for (int i = 0; i < NUM_CSR; i++)
         csr_shadow[i] = '0;
      mix_acc  = '0;
      step_ctr = '0;

      // Hold reset, release on a falling edge
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      idle_level = 1;
      test_data_before_init();
      test_byte_counts();
      test_key_extremes();
      test_drain_pause();
      test_random_stream();

      // Wait out the tail, then report
      drain_results();
      repeat (SETTLE_TICKS) @(posedge clock);
      if (pending_results.size() != 0)
         note_failure($sformatf("%0d results never arrived", pending_results.size()));
      if (failures == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

/* files.f */
sv/arxks_pkg.sv
sv/arxks_ctrl.sv
sv/arxks_dp.sv
sv/arx_stream_cipher_keystream.sv
tb/arx_stream_cipher_keystream_tb.sv
